// File: hw/rtl/abrc_pkg.sv
// Shared types and constants of the adaptive binary range coder.
// Holds item structs, table write/read request structs and the coder constants.
// No dependencies.
`default_nettype none

package abrc_pkg;

    // Table geometry and probability precision
    localparam int CONTEXT_BITS    = 18;
    localparam int PROB_USE_BITS   = 9;
    localparam int PROB_STORE_BITS = 16;
    localparam int TABLE_DEPTH     = 1 << CONTEXT_BITS;

    // Fixed field widths
    localparam int CTX_IN_BITS = 18;
    localparam int WORD_BITS   = 16;
    localparam int IVL_BITS    = 32;

    // Probability adaptation: move 1/64 of the distance toward the bit
    localparam int ADAPT_SHIFT = 6;
    localparam logic [PROB_STORE_BITS:0] ADAPT_ROUND =
        (PROB_STORE_BITS + 1)'((1 << ADAPT_SHIFT) - 1);
    localparam logic [PROB_STORE_BITS:0] PROB_FULL =
        {1'b1, {PROB_STORE_BITS{1'b0}}};
    localparam logic [PROB_STORE_BITS-1:0] PROB_HALF =
        {1'b1, {(PROB_STORE_BITS - 1){1'b0}}};

    // Emitted word counts
    localparam logic [1:0] WC_NONE = 2'd0;
    localparam logic [1:0] WC_ONE  = 2'd1;
    localparam logic [1:0] WC_TWO  = 2'd2;

    typedef enum logic {
        MODE_BIT  = 1'b0,   // code one bit
        MODE_CTRL = 1'b1    // flush (encode) or prime (decode)
    } t_mode;

    typedef enum logic {
        DIR_DECODE = 1'b0,
        DIR_ENCODE = 1'b1
    } t_dir;

    typedef logic [CONTEXT_BITS-1:0] t_ctx;

    typedef struct packed {
        t_mode                  mode;
        logic [CTX_IN_BITS-1:0] context_req;
        logic                   bit_in;
        logic [WORD_BITS-1:0]   stream_word;
    } t_in_item;

    typedef struct packed {
        logic [1:0]           word_count;
        logic [WORD_BITS-1:0] first_word;
        logic [WORD_BITS-1:0] second_word;
        logic                 bit_out;
        logic                 word_taken;
    } t_out_item;

    typedef struct packed {
        logic en;
        t_ctx ctx;
    } t_prob_rd;

    typedef struct packed {
        logic                       en;
        t_ctx                       ctx;
        logic [PROB_STORE_BITS-1:0] data;
    } t_prob_wr;

endpackage

`default_nettype wire

// File: hw/rtl/abrc_prob_store.sv
// Probability table: one-port-write, one-port-read synchronous memory,
// clearing sweep after reset and forwarding of the latest write.
// Depends on abrc_pkg.
`default_nettype none

module abrc_prob_store (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  abrc_pkg::t_prob_rd                    i_rd,
    input  abrc_pkg::t_prob_wr                    i_wr,
    input  abrc_pkg::t_ctx                        i_use_ctx,
    output logic [abrc_pkg::PROB_STORE_BITS-1:0]  o_prob,
    output logic                                  o_busy
);
    import abrc_pkg::*;

    logic [PROB_STORE_BITS-1:0] mem [TABLE_DEPTH];
    logic [PROB_STORE_BITS-1:0] r_rd_data;

    logic                       r_clr_busy, n_clr_busy;
    t_ctx                       r_clr_idx, n_clr_idx;
    logic                       r_fwd_valid, n_fwd_valid;
    t_ctx                       r_fwd_ctx;
    logic [PROB_STORE_BITS-1:0] r_fwd_data;

    logic                       wen;
    t_ctx                       waddr;
    logic [PROB_STORE_BITS-1:0] wdata;

    // Write port: clearing sweep owns it until done
    always_comb begin
        wen   = r_clr_busy | i_wr.en;
        waddr = r_clr_busy ? r_clr_idx : i_wr.ctx;
        wdata = r_clr_busy ? PROB_HALF : i_wr.data;
    end

    // Memory array, read data registered
    always_ff @(posedge i_clk) begin
        if (wen) begin
            mem[waddr] <= wdata;
        end
        if (i_rd.en) begin
            r_rd_data <= mem[i_rd.ctx];
        end
    end

    // Clear sweep and forwarding control
    always_comb begin
        n_clr_busy  = r_clr_busy;
        n_clr_idx   = r_clr_idx;
        n_fwd_valid = r_fwd_valid;
        if (r_clr_busy) begin
            n_clr_idx = r_clr_idx + 1'b1;
            if (&r_clr_idx) begin
                n_clr_busy = 1'b0;
            end
        end else if (i_wr.en) begin
            n_fwd_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_idx   <= '0;
            r_fwd_valid <= 1'b0;
        end else begin
            r_clr_busy  <= n_clr_busy;
            r_clr_idx   <= n_clr_idx;
            r_fwd_valid <= n_fwd_valid;
        end
    end

    // Latest item write, kept to cover a read issued at the same edge
    always_ff @(posedge i_clk) begin
        if (!r_clr_busy && i_wr.en) begin
            r_fwd_ctx  <= i_wr.ctx;
            r_fwd_data <= i_wr.data;
        end
    end

    assign o_prob = (r_fwd_valid && (r_fwd_ctx == i_use_ctx)) ? r_fwd_data : r_rd_data;
    assign o_busy = r_clr_busy;

    // No item traffic reaches the table during the clearing sweep
    a_clr_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> (!i_rd.en && !i_wr.en))
        else $error("table access during clear");

endmodule

`default_nettype wire

// File: hw/rtl/abrc_interval.sv
// Interval coder: low/range/code registers, renormalization, split multiply,
// bit decision and probability adaptation for the item in the coding stage.
// Depends on abrc_pkg.
`default_nettype none

module abrc_interval (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_adv,
    input  abrc_pkg::t_in_item                    i_item,
    input  wire [abrc_pkg::PROB_STORE_BITS-1:0]   i_prob,
    input  abrc_pkg::t_dir                        i_dir,
    output abrc_pkg::t_out_item                   o_result,
    output logic [abrc_pkg::PROB_STORE_BITS-1:0]  o_prob_new
);
    import abrc_pkg::*;

    logic [IVL_BITS-1:0] r_low,   n_low;
    logic [IVL_BITS-1:0] r_range, n_range;
    logic [IVL_BITS-1:0] r_code,  n_code;

    logic                       renorm;
    logic [WORD_BITS-1:0]       low_inv_lo;
    logic [WORD_BITS-1:0]       rng_cap;
    logic [IVL_BITS-1:0]        low_r, range_r, code_r;
    logic [PROB_USE_BITS-1:0]   p_use;
    logic [PROB_USE_BITS:0]     p_adj;
    logic [IVL_BITS:0]          prod;
    logic [IVL_BITS-1:0]        r2, mid;
    logic                       bit_val;
    logic [PROB_STORE_BITS:0]   dec_w, inc_w;

    // Renormalization by one word when range has dropped below the split unit
    always_comb begin
        renorm     = (r_range[IVL_BITS-1:PROB_USE_BITS] == '0);
        low_inv_lo = ~r_low[WORD_BITS-1:0];
        // range is capped so that low + range cannot wrap
        rng_cap    = (r_range[WORD_BITS-1:0] > low_inv_lo) ? low_inv_lo
                                                           : r_range[WORD_BITS-1:0];
        low_r      = renorm ? {r_low[WORD_BITS-1:0], {WORD_BITS{1'b0}}} : r_low;
        range_r    = renorm ? {rng_cap, {WORD_BITS{1'b1}}} : r_range;
        code_r     = (renorm && (i_dir == DIR_DECODE))
                   ? {r_code[WORD_BITS-1:0], i_item.stream_word} : r_code;
    end

    // Split point: scaled range times the cut probability
    always_comb begin
        p_use   = i_prob[PROB_STORE_BITS-1 -: PROB_USE_BITS];
        p_adj   = {1'b0, p_use} + {{PROB_USE_BITS{1'b0}}, ~p_use[PROB_USE_BITS-1]};
        prod    = range_r[IVL_BITS-1:PROB_USE_BITS] * p_adj;
        r2      = prod[IVL_BITS-1:0];
        mid     = low_r + r2;
        bit_val = (i_dir == DIR_ENCODE) ? i_item.bit_in : (code_r >= mid);
    end

    // Probability moves toward the coded bit
    always_comb begin
        dec_w = ({1'b0, i_prob} + ADAPT_ROUND) >> ADAPT_SHIFT;
        inc_w = (PROB_FULL - {1'b0, i_prob}) >> ADAPT_SHIFT;
        o_prob_new = bit_val ? (i_prob - dec_w[PROB_STORE_BITS-1:0])
                             : (i_prob + inc_w[PROB_STORE_BITS-1:0]);
    end

    // Next interval state and result item
    always_comb begin
        n_low    = r_low;
        n_range  = r_range;
        n_code   = r_code;
        o_result = '0;
        unique case (i_item.mode)
            MODE_CTRL: begin
                n_low   = '0;
                n_range = '1;
                if (i_dir == DIR_ENCODE) begin
                    o_result.word_count  = WC_TWO;
                    o_result.first_word  = r_low[IVL_BITS-1:WORD_BITS];
                    o_result.second_word = r_low[WORD_BITS-1:0];
                    n_code               = '0;
                end else begin
                    o_result.word_taken = 1'b1;
                    n_code              = {r_code[WORD_BITS-1:0], i_item.stream_word};
                end
            end
            MODE_BIT: begin
                if (renorm) begin
                    if (i_dir == DIR_ENCODE) begin
                        o_result.word_count = WC_ONE;
                        o_result.first_word = r_low[IVL_BITS-1:WORD_BITS];
                    end else begin
                        o_result.word_taken = 1'b1;
                    end
                end
                n_code           = code_r;
                n_low            = bit_val ? mid : low_r;
                n_range          = bit_val ? (range_r - r2) : (r2 - 1'b1);
                o_result.bit_out = bit_val;
            end
            default: begin
                o_result = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low   <= '0;
            r_range <= '1;
            r_code  <= '0;
        end else if (i_adv) begin
            r_low   <= n_low;
            r_range <= n_range;
            r_code  <= n_code;
        end
    end

    // A flush or prime item always restarts the interval
    a_ctrl_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && (i_item.mode == MODE_CTRL)) |=> ((r_range == '1) && (r_low == '0)))
        else $error("interval not restarted after control item");

endmodule

`default_nettype wire

// File: hw/rtl/adaptive_binary_range_coder.sv
// Top level of the adaptive binary range coder: handshakes, coding stage,
// output register and direction register. Depends on abrc_pkg,
// abrc_prob_store and abrc_interval.
//
//  Channel | Signals                              | Direction
//  --------+--------------------------------------+-----------
//  in      | i_in_valid, o_in_ready, i_in_item    | item in
//  out     | o_out_valid, i_out_ready, o_out_item | result out
//  cfg     | i_cfg_we, i_cfg_wdata (direction)    | write only
//
// One item per cycle sustained while the output takes results; the table read
// and the registering of the item into the coding stage happen at the accepting
// edge, then the coding stage with its single multiply feeds the output register.
// The pace is set by the interval update and the table read-modify-write, with
// the latest write forwarded to a read of the same context.
// After reset the table is cleared to one half, one entry per cycle, with
// o_in_ready low over all 262144 entries; configuration writes are taken any time.
// A stalled output holds the coding stage, which then holds the input.
`default_nettype none

module adaptive_binary_range_coder (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  abrc_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output abrc_pkg::t_out_item  o_out_item,
    input  wire                  i_cfg_we,
    input  wire                  i_cfg_wdata
);
    import abrc_pkg::*;

    t_dir       r_direction;
    logic       r_s1_valid;
    t_in_item   r_s1_item;
    logic       r_out_valid;
    t_out_item  r_out_item;

    logic                       accept;
    logic                       s1_adv;
    logic                       busy;
    t_prob_rd                   rd_req;
    t_prob_wr                   wr_req;
    logic [PROB_STORE_BITS-1:0] prob;
    logic [PROB_STORE_BITS-1:0] prob_new;
    t_out_item                  result;
    t_ctx                       s1_ctx;

    // Handshake and stage advance
    always_comb begin
        s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
        o_in_ready = !busy && (!r_s1_valid || s1_adv);
        accept     = i_in_valid && o_in_ready;
        s1_ctx     = r_s1_item.context_req[CONTEXT_BITS-1:0];
    end

    // Table requests: read on accept, write back when a bit item leaves the stage
    always_comb begin
        rd_req.en   = accept;
        rd_req.ctx  = i_in_item.context_req[CONTEXT_BITS-1:0];
        wr_req.en   = s1_adv && (r_s1_item.mode == MODE_BIT);
        wr_req.ctx  = s1_ctx;
        wr_req.data = prob_new;
    end

    abrc_prob_store u_prob_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd      (rd_req),
        .i_wr      (wr_req),
        .i_use_ctx (s1_ctx),
        .o_prob    (prob),
        .o_busy    (busy)
    );

    abrc_interval u_interval (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (s1_adv),
        .i_item     (r_s1_item),
        .i_prob     (prob),
        .i_dir      (r_direction),
        .o_result   (result),
        .o_prob_new (prob_new)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= DIR_ENCODE;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_direction <= t_dir'(i_cfg_wdata);
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_item <= i_in_item;
        end
        if (s1_adv) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // An item in the coding stage reaches an empty output register next cycle
    a_s1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !r_out_valid) |=> r_out_valid)
        else $error("coding stage did not advance into empty output");

    // A flush result carries no bit and consumes no word
    a_flush_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.word_count == WC_TWO))
            |-> (!o_out_item.bit_out && !o_out_item.word_taken))
        else $error("malformed flush result");

endmodule

`default_nettype wire
